[rtl/subsampled_luma_average_top_defines.svh]
// Assertion macros used by the checker file of the luma average block.
`ifndef SUBSAMPLED_LUMA_AVERAGE_TOP_DEFINES_SVH
`define SUBSAMPLED_LUMA_AVERAGE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SLA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define SLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sla_pkg.sv]
// Shared types and constants of the subsampled luma average block.
`timescale 1ns / 1ps

package sla_pkg;

	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int PIX_W       = 8;
	localparam int BRIGHT_W    = 17;
	localparam int SAMPLES_W   = 14;
	localparam int LUMA_W      = 24;
	localparam int WEIGHT_W    = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_GRID       = 64;

	localparam int RESET_SIZE = 64;

	// Rec.601 weights in Q16
	localparam logic [WEIGHT_W-1:0] W_RED   = 16'd19595;
	localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd38470;
	localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd7471;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_CHANNEL_ORDER = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             sampled;
		logic             last;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pix_entry_t;

endpackage

[rtl/sla_config.sv]
// Configuration registers with size clamping and sampling step computation.
`timescale 1ns / 1ps

module sla_config import sla_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int GRID       = DEF_GRID,
	localparam int XPOS_W    = $clog2(MAX_WIDTH),
	localparam int YPOS_W    = $clog2(MAX_HEIGHT),
	localparam int XSTEP_MAX = (MAX_WIDTH / GRID > 0) ? MAX_WIDTH / GRID : 1,
	localparam int YSTEP_MAX = (MAX_HEIGHT / GRID > 0) ? MAX_HEIGHT / GRID : 1,
	localparam int XSTEP_W   = $clog2(XSTEP_MAX + 1),
	localparam int YSTEP_W   = $clog2(YSTEP_MAX + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic [XPOS_W-1:0]    x_last,
	output logic [YPOS_W-1:0]    y_last,
	output logic [XSTEP_W-1:0]   x_step,
	output logic [YSTEP_W-1:0]   y_step,
	output logic                 order
);

	localparam int MAX_SIZE  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int SZ_W      = ($clog2(MAX_SIZE + 1) > CFG_W) ? $clog2(MAX_SIZE + 1) : CFG_W;
	localparam int STEP_W    = (XSTEP_W > YSTEP_W) ? XSTEP_W : YSTEP_W;
	// exact floor division by GRID for any CFG_W-bit size
	localparam int RECIP_SH  = CFG_W + 9;
	localparam int PROD_W    = RECIP_SH + STEP_W;
	localparam int RECIP     = ((1 << RECIP_SH) + GRID - 1) / GRID;
	localparam int XSTEP_RST = (RESET_SIZE / GRID > 0) ? RESET_SIZE / GRID : 1;
	localparam int YSTEP_RST = XSTEP_RST;

	logic [SZ_W-1:0]   raw_c;
	logic [SZ_W-1:0]   limit_c;
	logic [SZ_W-1:0]   size_c;
	logic [SZ_W-1:0]   last_c;
	logic [PROD_W-1:0] prod_c;
	logic [STEP_W-1:0] quo_c;
	logic [STEP_W-1:0] step_c;
	logic [XPOS_W-1:0] x_last_q;
	logic [YPOS_W-1:0] y_last_q;
	logic [XSTEP_W-1:0] x_step_q;
	logic [YSTEP_W-1:0] y_step_q;
	logic              order_q;

	assign cfg_ready = 1'b1;

	always_comb begin
		raw_c   = SZ_W'(cfg_data);
		limit_c = (cfg_index == REG_FRAME_HEIGHT) ? SZ_W'(MAX_HEIGHT) : SZ_W'(MAX_WIDTH);
		if (raw_c == '0) begin
			size_c = SZ_W'(1);
		end else if (raw_c > limit_c) begin
			size_c = limit_c;
		end else begin
			size_c = raw_c;
		end
		last_c = size_c - SZ_W'(1);
		prod_c = PROD_W'(size_c) * PROD_W'(RECIP);
		quo_c  = prod_c[RECIP_SH +: STEP_W];
		step_c = (quo_c == '0) ? STEP_W'(1) : quo_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_last_q <= XPOS_W'(RESET_SIZE - 1);
			y_last_q <= YPOS_W'(RESET_SIZE - 1);
			x_step_q <= XSTEP_W'(XSTEP_RST);
			y_step_q <= YSTEP_W'(YSTEP_RST);
			order_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					x_last_q <= XPOS_W'(last_c);
					x_step_q <= XSTEP_W'(step_c);
				end
				REG_FRAME_HEIGHT: begin
					y_last_q <= YPOS_W'(last_c);
					y_step_q <= YSTEP_W'(step_c);
				end
				REG_CHANNEL_ORDER: begin
					order_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign x_last = x_last_q;
	assign y_last = y_last_q;
	assign x_step = x_step_q;
	assign y_step = y_step_q;
	assign order  = order_q;

endmodule

[rtl/sla_front.sv]
// Front end: accepts pixels, tracks raster position and sampling phase, tags grid pixels.
`timescale 1ns / 1ps

module sla_front import sla_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int GRID       = DEF_GRID,
	localparam int XPOS_W    = $clog2(MAX_WIDTH),
	localparam int YPOS_W    = $clog2(MAX_HEIGHT),
	localparam int XSTEP_MAX = (MAX_WIDTH / GRID > 0) ? MAX_WIDTH / GRID : 1,
	localparam int YSTEP_MAX = (MAX_HEIGHT / GRID > 0) ? MAX_HEIGHT / GRID : 1,
	localparam int XSTEP_W   = $clog2(XSTEP_MAX + 1),
	localparam int YSTEP_W   = $clog2(YSTEP_MAX + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [PIX_W-1:0]   first_byte,
	input  logic [PIX_W-1:0]   middle_byte,
	input  logic [PIX_W-1:0]   third_byte,
	input  logic [XPOS_W-1:0]  x_last,
	input  logic [YPOS_W-1:0]  y_last,
	input  logic [XSTEP_W-1:0] x_step,
	input  logic [YSTEP_W-1:0] y_step,
	input  logic               order,
	input  logic               q_full,
	output logic               q_push,
	output pix_entry_t         q_entry
);

	localparam int XPH_W  = (XSTEP_MAX > 1) ? $clog2(XSTEP_MAX) : 1;
	localparam int YPH_W  = (YSTEP_MAX > 1) ? $clog2(YSTEP_MAX) : 1;
	localparam int XCMP_W = XPH_W + 1;
	localparam int YCMP_W = YPH_W + 1;

	logic [XPOS_W-1:0] col_q;
	logic [YPOS_W-1:0] row_q;
	logic [XPH_W-1:0]  colph_q;
	logic [YPH_W-1:0]  rowph_q;
	logic              row_end;
	logic              frame_end;
	logic [XCMP_W-1:0] colph_inc;
	logic [YCMP_W-1:0] rowph_inc;
	logic [XPH_W-1:0]  colph_nx;
	logic [YPH_W-1:0]  rowph_nx;

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		row_end   = col_q >= x_last;
		frame_end = row_end && (row_q >= y_last);
		colph_inc = XCMP_W'(colph_q) + XCMP_W'(1);
		rowph_inc = YCMP_W'(rowph_q) + YCMP_W'(1);
		colph_nx  = (colph_inc >= XCMP_W'(x_step)) ? '0 : XPH_W'(colph_inc);
		rowph_nx  = (rowph_inc >= YCMP_W'(y_step)) ? '0 : YPH_W'(rowph_inc);

		q_entry.sampled = (colph_q == '0) && (rowph_q == '0);
		q_entry.last    = frame_end;
		q_entry.red     = order ? first_byte : third_byte;
		q_entry.green   = middle_byte;
		q_entry.blue    = order ? third_byte : first_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			colph_q <= '0;
			rowph_q <= '0;
		end else if (q_push) begin
			if (frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				colph_q <= '0;
				rowph_q <= '0;
			end else if (row_end) begin
				col_q   <= '0;
				colph_q <= '0;
				row_q   <= row_q + YPOS_W'(1);
				rowph_q <= rowph_nx;
			end else begin
				col_q   <= col_q + XPOS_W'(1);
				colph_q <= colph_nx;
			end
		end
	end

endmodule

[rtl/sla_queue.sv]
// Short queue of tagged pixels between the front end and the back end.
`timescale 1ns / 1ps

module sla_queue import sla_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pix_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output pix_entry_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pix_entry_t       slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] fill_q;

	assign full  = fill_q == CNT_W'(QUEUE_DEPTH);
	assign empty = fill_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/sla_back.sv]
// Back end: luma weighting, frame accumulation, serial mean divider and result register.
`timescale 1ns / 1ps

module sla_back import sla_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  pix_entry_t           q_head,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [BRIGHT_W-1:0]  brightness,
	output logic [SAMPLES_W-1:0] samples_taken
);

	localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int TOT_W  = CNT_W + LUMA_W;
	localparam int D_W    = CNT_W + PIX_W;
	localparam int BIT_W  = $clog2(BRIGHT_W);

	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_DONE = 3'b100
	} div_state_t;

	div_state_t         div_state_q;
	logic               valid_s1;
	logic               sampled_s1;
	logic               last_s1;
	logic [LUMA_W-1:0]  luma_s1;
	logic [LUMA_W-1:0]  luma_c;
	logic               acc_fire;
	logic               s1_take;
	logic [TOT_W-1:0]   tot_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TOT_W-1:0]   tot_nx;
	logic [CNT_W-1:0]   cnt_nx;
	logic [D_W-1:0]     dvs_c;
	logic [TOT_W-1:0]   rem_q;
	logic [TOT_W-1:0]   dvs_q;
	logic [BRIGHT_W-1:0] quo_q;
	logic [CNT_W-1:0]   cnt_div_q;
	logic [BIT_W-1:0]   bit_q;
	logic               ge;
	logic               out_free;
	logic               out_valid_q;
	logic [BRIGHT_W-1:0] bright_q;
	logic [CNT_W-1:0]   samp_q;

	always_comb begin
		luma_c = LUMA_W'(W_RED) * LUMA_W'(q_head.red)
			+ LUMA_W'(W_GREEN) * LUMA_W'(q_head.green)
			+ LUMA_W'(W_BLUE) * LUMA_W'(q_head.blue);
		acc_fire = valid_s1 && !(last_s1 && (div_state_q != DIV_IDLE));
		s1_take  = !valid_s1 || acc_fire;
		q_pop    = s1_take && !q_empty;
		tot_nx   = tot_q + (sampled_s1 ? TOT_W'(luma_s1) : '0);
		cnt_nx   = cnt_q + CNT_W'(sampled_s1);
		dvs_c    = {cnt_nx, {PIX_W{1'b0}}} - D_W'(cnt_nx);
		ge       = rem_q >= dvs_q;
		out_free = !out_valid_q || pop;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sampled_s1 <= q_head.sampled;
			last_s1    <= q_head.last;
			luma_s1    <= luma_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			tot_q       <= '0;
			cnt_q       <= '0;
			div_state_q <= DIV_IDLE;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_take) begin
				valid_s1 <= !q_empty;
			end
			if (acc_fire) begin
				if (last_s1) begin
					tot_q <= '0;
					cnt_q <= '0;
				end else begin
					tot_q <= tot_nx;
					cnt_q <= cnt_nx;
				end
			end
			if (pop && (div_state_q != DIV_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (div_state_q)
				DIV_IDLE: begin
					if (acc_fire && last_s1) begin
						div_state_q <= DIV_RUN;
						bit_q       <= BIT_W'(BRIGHT_W - 1);
					end
				end
				DIV_RUN: begin
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == '0) begin
						div_state_q <= DIV_DONE;
					end
				end
				DIV_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						div_state_q <= DIV_IDLE;
					end
				end
				default: begin
					div_state_q <= DIV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((div_state_q == DIV_IDLE) && acc_fire && last_s1) begin
			rem_q     <= tot_nx;
			dvs_q     <= TOT_W'(dvs_c) << (BRIGHT_W - 1);
			quo_q     <= '0;
			cnt_div_q <= cnt_nx;
		end else if (div_state_q == DIV_RUN) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[BRIGHT_W-2:0], ge};
			dvs_q <= dvs_q >> 1;
		end
		if ((div_state_q == DIV_DONE) && out_free) begin
			bright_q <= quo_q;
			samp_q   <= cnt_div_q;
		end
	end

	assign empty         = !out_valid_q;
	assign brightness    = bright_q;
	assign samples_taken = SAMPLES_W'(samp_q);

endmodule

[rtl/subsampled_luma_average_top.sv]
// Top level of the subsampled Rec.601 luma average block.
`timescale 1ns / 1ps

// Pixels of one frame are pushed in raster order at one pixel per clock; push is
// refused only when the four-entry pixel queue is full. Pixels on a grid of step
// max(1, size/GRID) in each direction are weighted with Q16 Rec.601 luma weights and
// summed. A pixel passes a queue slot and the weighting stage register before it is
// accumulated. On the frame's last pixel a restoring divider forms
// floor(total / (255 * count)), one quotient bit per cycle, and hands it to the result
// register. The divider runs alongside the next frame's accumulation; only a next
// frame end that reaches the back end while the divider is busy, still dividing or
// holding its quotient behind an unread result, holds the back end and fills the
// queue. Width and height writes are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT; the
// user must write configuration only with no frame in flight, which the block does
// not enforce.

module subsampled_luma_average_top import sla_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int GRID       = DEF_GRID
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [PIX_W-1:0]     first_byte,
	input  logic [PIX_W-1:0]     middle_byte,
	input  logic [PIX_W-1:0]     third_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic [BRIGHT_W-1:0]  brightness,
	output logic [SAMPLES_W-1:0] samples_taken,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int XPOS_W    = $clog2(MAX_WIDTH);
	localparam int YPOS_W    = $clog2(MAX_HEIGHT);
	localparam int XSTEP_MAX = (MAX_WIDTH / GRID > 0) ? MAX_WIDTH / GRID : 1;
	localparam int YSTEP_MAX = (MAX_HEIGHT / GRID > 0) ? MAX_HEIGHT / GRID : 1;
	localparam int XSTEP_W   = $clog2(XSTEP_MAX + 1);
	localparam int YSTEP_W   = $clog2(YSTEP_MAX + 1);

	logic [XPOS_W-1:0]  x_last;
	logic [YPOS_W-1:0]  y_last;
	logic [XSTEP_W-1:0] x_step;
	logic [YSTEP_W-1:0] y_step;
	logic               order;
	logic               q_full;
	logic               q_push;
	pix_entry_t         q_entry;
	logic               q_pop;
	logic               q_empty;
	pix_entry_t         q_head;

	sla_config #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.GRID       (GRID)
	) u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.x_last    (x_last),
		.y_last    (y_last),
		.x_step    (x_step),
		.y_step    (y_step),
		.order     (order)
	);

	sla_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.GRID       (GRID)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.first_byte  (first_byte),
		.middle_byte (middle_byte),
		.third_byte  (third_byte),
		.x_last      (x_last),
		.y_last      (y_last),
		.x_step      (x_step),
		.y_step      (y_step),
		.order       (order),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	sla_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	sla_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.brightness    (brightness),
		.samples_taken (samples_taken)
	);

endmodule

[rtl/sla_checker.sv]
// Port-level assertions for the luma average block and their bind.
`timescale 1ns / 1ps
`include "subsampled_luma_average_top_defines.svh"

module sla_checker import sla_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input logic                 full,
	input logic                 empty,
	input logic                 pop,
	input logic [BRIGHT_W-1:0]  brightness,
	input logic [SAMPLES_W-1:0] samples_taken
);

	`SLA_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(brightness) && $stable(samples_taken), "result changed while stalled")
	`SLA_ASSERT_IMPL(a_bright_range, !empty, brightness <= 17'd65536, "brightness above full scale")
	`SLA_ASSERT_IMPL(a_empty_after_pop, $rose(empty), $past(pop), "result dropped without a pop beat")
	`SLA_ASSERT_IMPL(a_full_after_push, $rose(full), $past(push), "queue filled without a push beat")

endmodule

bind subsampled_luma_average_top sla_checker u_sla_checker (.*);
